// File: sv/lsbs_pkg.sv
// Shared widths, codes and constants of the LSB pixel steganography engine.
`default_nettype none

package lsbs_pkg;

  // Field widths of the input and result words.
  localparam int unsigned OP_W        = 2;
  localparam int unsigned CHAN_W      = 8;
  localparam int unsigned PIX_COUNT_W = 25;

  // Default depth of the message store, in bytes.
  localparam int unsigned MSG_BYTES_DEF = 256;

  // Configuration port.
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = PIX_COUNT_W;
  localparam logic [CFG_IDX_W-1:0] REG_MODE        = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PIXEL_COUNT = 1'd1;

  // Reset value of the pixel count register.
  localparam logic [PIX_COUNT_W-1:0] PIX_COUNT_RST = 25'd1;

  // Operation codes of an input word.
  localparam logic [OP_W-1:0] OP_LOAD  = 2'd0;
  localparam logic [OP_W-1:0] OP_PIXEL = 2'd1;
  localparam logic [OP_W-1:0] OP_CLEAR = 2'd2;

  // Mode register values.
  localparam logic MODE_EMBED   = 1'b0;
  localparam logic MODE_EXTRACT = 1'b1;

  // Result kinds.
  localparam logic KIND_PIXEL = 1'b0;
  localparam logic KIND_BYTE  = 1'b1;

  // Mask that clears a channel's least significant bit.
  localparam logic [CHAN_W-1:0] LSB_CLEAR = 8'hFE;

  // Channels per pixel.
  localparam int unsigned CHANNELS = 3;

endpackage : lsbs_pkg

`default_nettype wire

// File: sv/lsbs_in_if.sv
// Input channel: one word carries an operation, a message byte and a pixel.
`default_nettype none

interface lsbs_in_if
  import lsbs_pkg::*;
;
  logic              valid;
  logic              ready;
  logic [OP_W-1:0]   op;
  logic [CHAN_W-1:0] message_byte;
  logic [CHAN_W-1:0] chan_zero;
  logic [CHAN_W-1:0] chan_one;
  logic [CHAN_W-1:0] chan_two;

  modport source (
    output valid, op, message_byte, chan_zero, chan_one, chan_two,
    input  ready
  );

  modport sink (
    input  valid, op, message_byte, chan_zero, chan_one, chan_two,
    output ready
  );
endinterface : lsbs_in_if

`default_nettype wire

// File: sv/lsbs_out_if.sv
// Result channel: one word carries a processed pixel or an extracted byte.
`default_nettype none

interface lsbs_out_if
  import lsbs_pkg::*;
;
  logic              valid;
  logic              ready;
  logic              kind;
  logic [CHAN_W-1:0] out_chan_zero;
  logic [CHAN_W-1:0] out_chan_one;
  logic [CHAN_W-1:0] out_chan_two;
  logic [CHAN_W-1:0] extracted_byte;
  logic              no_room;

  modport source (
    output valid, kind, out_chan_zero, out_chan_one, out_chan_two,
           extracted_byte, no_room,
    input  ready
  );

  modport sink (
    input  valid, kind, out_chan_zero, out_chan_one, out_chan_two,
           extracted_byte, no_room,
    output ready
  );
endinterface : lsbs_out_if

`default_nettype wire

// File: sv/lsb_pixel_stego_engine.sv
// Top level of the LSB pixel steganography engine.
`default_nettype none

// The engine takes one input word per clock and returns at most one result
// word per input through a result register. The input is held off only while a
// finished result waits and the receiver is not ready, so words follow back to
// back whenever results are taken. Message bytes are appended with the load
// operation; in embed mode each pixel word comes back with up to three channel
// LSBs replaced by the next message bits (first channel first, bytes most
// significant bit first), and unchanged with no_room set when the message does
// not fit the configured pixel count. In extract mode channel LSBs are packed
// into bytes and a byte word is returned when eight bits have gathered. The
// message store is a memory with two read ports whose registered outputs
// always hold the byte under the current bit position and the one after it, so
// consecutive pixels need no wait. The store needs no clearing pass after
// reset. Configuration must be written only while the engine is idle; the
// engine itself does not enforce this.
module lsb_pixel_stego_engine
  import lsbs_pkg::*;
#(
  parameter int unsigned MSG_BYTES = MSG_BYTES_DEF
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_data_i,
  lsbs_in_if.sink                    in_port,
  lsbs_out_if.source                 out_port
);

  localparam int unsigned AW     = (MSG_BYTES > 1) ? $clog2(MSG_BYTES) : 1;
  localparam int unsigned LEN_W  = $clog2(MSG_BYTES + 1);
  localparam int unsigned POS_W  = LEN_W + 3;
  localparam int unsigned ROOM_W = PIX_COUNT_W + 2;
  localparam int unsigned CMP_W  = (ROOM_W > POS_W) ? ROOM_W : POS_W;
  localparam logic [LEN_W-1:0] LEN_FULL = LEN_W'(MSG_BYTES);

  // Configuration and state registers.
  logic              mode_q;
  logic [ROOM_W-1:0] room_q;
  logic [LEN_W-1:0]  len_q, len_d;
  logic [POS_W-1:0]  pos_q, pos_d;
  logic [6:0]        gbits_q, gbits_d;
  logic [2:0]        gcnt_q, gcnt_d;

  // Result register.
  logic              out_valid_q;
  logic              kind_q, kind_d;
  logic [CHAN_W-1:0] oc0_q, oc0_d;
  logic [CHAN_W-1:0] oc1_q, oc1_d;
  logic [CHAN_W-1:0] oc2_q, oc2_d;
  logic [CHAN_W-1:0] xbyte_q, xbyte_d;
  logic              no_room_q, no_room_d;
  logic              res_d;

  // Handshake.
  logic in_acc;
  logic out_free;
  logic load_en;

  // Store read data for the current bit position.
  logic [CHAN_W-1:0] byte_a, byte_b;

  // Embed path signals.
  logic [POS_W-1:0]  total_bits;
  logic              room_short;
  logic [POS_W-1:0]  p_k   [CHANNELS];
  logic              use_k [CHANNELS];
  logic              bit_k [CHANNELS];
  logic [CHAN_W-1:0] ch_in [CHANNELS];
  logic [CHAN_W-1:0] ch_emb[CHANNELS];
  logic [1:0]        n_bits;

  // Extract path signals.
  logic [7:0]        acc;
  logic [3:0]        cnt;
  logic              got_byte;
  logic [7:0]        got_val;

  assign out_free       = !out_valid_q || out_port.ready;
  assign in_port.ready  = out_free;
  assign in_acc         = in_port.valid && out_free;
  assign load_en        = in_acc && (in_port.op == OP_LOAD) && (len_q < LEN_FULL);

  // Message store.
  lsbs_msg_store #(
    .MSG_BYTES (MSG_BYTES),
    .AW        (AW)
  ) u_store (
    .clk_i       (clk_i),
    .wr_en_i     (load_en),
    .wr_addr_i   (len_q[AW-1:0]),
    .wr_data_i   (in_port.message_byte),
    .rd_addr_a_i (pos_d[AW+2:3]),
    .rd_addr_b_i (pos_d[AW+2:3] + AW'(1)),
    .rd_data_a_o (byte_a),
    .rd_data_b_o (byte_b)
  );

  assign ch_in[0] = in_port.chan_zero;
  assign ch_in[1] = in_port.chan_one;
  assign ch_in[2] = in_port.chan_two;

  // Capacity check and per-channel bit selection for embedding.
  assign total_bits = {len_q, 3'b000};
  assign room_short = (len_q != '0) && (CMP_W'(room_q) < CMP_W'(total_bits));

  always_comb begin
    n_bits = '0;
    for (int k = 0; k < CHANNELS; k++) begin
      p_k[k]   = pos_q + POS_W'(k);
      use_k[k] = !room_short && (p_k[k] < total_bits);
      if (p_k[k][POS_W-1:3] == pos_q[POS_W-1:3]) begin
        bit_k[k] = byte_a[~p_k[k][2:0]];
      end else begin
        bit_k[k] = byte_b[~p_k[k][2:0]];
      end
      if (use_k[k]) begin
        ch_emb[k] = (ch_in[k] & LSB_CLEAR) | {{(CHAN_W-1){1'b0}}, bit_k[k]};
        n_bits    = n_bits + 2'd1;
      end else begin
        ch_emb[k] = ch_in[k];
      end
    end
  end

  // Bit gathering for extraction.
  always_comb begin
    acc      = {1'b0, gbits_q};
    cnt      = {1'b0, gcnt_q};
    got_byte = 1'b0;
    got_val  = '0;
    for (int k = 0; k < CHANNELS; k++) begin
      acc = {acc[6:0], ch_in[k][0]};
      cnt = cnt + 4'd1;
      if (cnt == 4'd8) begin
        got_val  = acc;
        got_byte = 1'b1;
        acc      = '0;
        cnt      = '0;
      end
    end
  end

  // Next state and result for an accepted word.
  always_comb begin
    len_d     = len_q;
    pos_d     = pos_q;
    gbits_d   = gbits_q;
    gcnt_d    = gcnt_q;
    res_d     = 1'b0;
    kind_d    = KIND_PIXEL;
    oc0_d     = '0;
    oc1_d     = '0;
    oc2_d     = '0;
    xbyte_d   = '0;
    no_room_d = 1'b0;
    if (in_acc) begin
      case (in_port.op)
        OP_LOAD: begin
          if (load_en) begin
            len_d = len_q + LEN_W'(1);
          end
        end
        OP_CLEAR: begin
          len_d   = '0;
          pos_d   = '0;
          gbits_d = '0;
          gcnt_d  = '0;
        end
        OP_PIXEL: begin
          if (mode_q == MODE_EMBED) begin
            res_d     = 1'b1;
            no_room_d = room_short;
            oc0_d     = ch_emb[0];
            oc1_d     = ch_emb[1];
            oc2_d     = ch_emb[2];
            pos_d     = pos_q + POS_W'(n_bits);
          end else begin
            res_d   = got_byte;
            kind_d  = KIND_BYTE;
            xbyte_d = got_val;
            gbits_d = acc[6:0];
            gcnt_d  = cnt[2:0];
          end
        end
        default: begin
        end
      endcase
    end
  end

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= MODE_EMBED;
      room_q <= ROOM_W'(PIX_COUNT_RST) * ROOM_W'(CHANNELS);
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_MODE:        mode_q <= cfg_data_i[0];
        REG_PIXEL_COUNT: room_q <= ROOM_W'({cfg_data_i, 1'b0}) + ROOM_W'(cfg_data_i);
        default: begin
        end
      endcase
    end
  end

  // Position and gather state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q   <= '0;
      pos_q   <= '0;
      gbits_q <= '0;
      gcnt_q  <= '0;
    end else begin
      len_q   <= len_d;
      pos_q   <= pos_d;
      gbits_q <= gbits_d;
      gcnt_q  <= gcnt_d;
    end
  end

  // Result valid.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= res_d;
    end
  end

  // Result payload.
  always_ff @(posedge clk_i) begin
    if (out_free) begin
      kind_q    <= kind_d;
      oc0_q     <= oc0_d;
      oc1_q     <= oc1_d;
      oc2_q     <= oc2_d;
      xbyte_q   <= xbyte_d;
      no_room_q <= no_room_d;
    end
  end

  assign out_port.valid          = out_valid_q;
  assign out_port.kind           = kind_q;
  assign out_port.out_chan_zero  = oc0_q;
  assign out_port.out_chan_one   = oc1_q;
  assign out_port.out_chan_two   = oc2_q;
  assign out_port.extracted_byte = xbyte_q;
  assign out_port.no_room        = no_room_q;

  // The embed position never runs past the loaded message.
  a_pos_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    pos_q <= total_bits)
    else $error("bit position beyond message length");

  // A byte load into a store with room grows the message by one.
  a_len_grow : assert property (@(posedge clk_i) disable iff (!rst_ni)
    load_en |=> (len_q == $past(len_q) + LEN_W'(1)))
    else $error("message length did not advance on load");

  // An extracted byte never carries the capacity flag.
  a_byte_flag : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && (kind_q == KIND_BYTE)) |-> !no_room_q)
    else $error("capacity flag set on extracted byte");

  // The gather count holds across embed mode pixel words.
  a_gcnt_hold : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && (in_port.op == OP_PIXEL) && (mode_q == MODE_EMBED))
      |=> $stable(gcnt_q))
    else $error("gather count changed in embed mode");

endmodule : lsb_pixel_stego_engine

`default_nettype wire

// File: sv/lsbs_msg_store.sv
// Message byte store: one write port and two registered read ports.
`default_nettype none

module lsbs_msg_store
  import lsbs_pkg::*;
#(
  parameter int unsigned MSG_BYTES = MSG_BYTES_DEF,
  parameter int unsigned AW        = (MSG_BYTES > 1) ? $clog2(MSG_BYTES) : 1
) (
  input  wire logic              clk_i,
  input  wire logic              wr_en_i,
  input  wire logic [AW-1:0]     wr_addr_i,
  input  wire logic [CHAN_W-1:0] wr_data_i,
  input  wire logic [AW-1:0]     rd_addr_a_i,
  input  wire logic [AW-1:0]     rd_addr_b_i,
  output logic      [CHAN_W-1:0] rd_data_a_o,
  output logic      [CHAN_W-1:0] rd_data_b_o
);

  logic [CHAN_W-1:0] mem [MSG_BYTES];

  // Write port.
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
  end

  // Read ports; a byte written in the same cycle is passed straight through.
  always_ff @(posedge clk_i) begin
    if (wr_en_i && (wr_addr_i == rd_addr_a_i)) begin
      rd_data_a_o <= wr_data_i;
    end else begin
      rd_data_a_o <= mem[rd_addr_a_i];
    end
    if (wr_en_i && (wr_addr_i == rd_addr_b_i)) begin
      rd_data_b_o <= wr_data_i;
    end else begin
      rd_data_b_o <= mem[rd_addr_b_i];
    end
  end

endmodule : lsbs_msg_store

`default_nettype wire
